// ----- rtl/rspe_pkg.sv -----
// shared types, constants and gf(256) helpers for the reed-solomon parity encoder
// no dependencies; imported by every rtl module of the block
package rspe_pkg;

  localparam int PARITY_COUNT = 26;
  localparam int CNT_W        = $clog2(PARITY_COUNT + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] GF_POLY_LOW = 8'h1D;
  localparam logic [7:0] GF_ALPHA    = 8'h02;

  typedef logic [7:0] byte_t;
  typedef logic [PARITY_COUNT-1:0][7:0] rem_t;

  typedef struct packed {
    byte_t data;
    logic  eom;
  } q_item_t;

  typedef struct packed {
    logic valid;
    rem_t parity;
  } load_t;

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    acc = '0;
    for (int bit_i = 7; bit_i >= 0; bit_i--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_POLY_LOW : 8'h00);
      if (b[bit_i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  // generator = prod (x - 2^i), monic term implicit, highest degree first
  function automatic rem_t build_gen();
    rem_t  g;
    byte_t root;
    g = '0;
    g[PARITY_COUNT-1] = 8'h01;
    root = 8'h01;
    for (int r = 0; r < PARITY_COUNT; r++) begin
      for (int k = 0; k < PARITY_COUNT - 1; k++) begin
        g[k] = gf_mul(g[k], root) ^ g[k+1];
      end
      g[PARITY_COUNT-1] = gf_mul(g[PARITY_COUNT-1], root);
      root = gf_mul(root, GF_ALPHA);
    end
    return g;
  endfunction

  localparam rem_t GEN_COEF = build_gen();

endpackage

// ----- rtl/rspe_queue.sv -----
// front end: small input queue holding accepted message bytes and end marks
// depends on rspe_pkg
module rspe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_message,
  output logic              q_valid,
  output rspe_pkg::q_item_t q_item,
  input  logic              q_pop
);
  import rspe_pkg::*;

  q_item_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               push;
  logic               pop;

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_valid && q_pop;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_data_byte, eom: in_end_of_message};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_changes_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> rd_ptr_r == $past(rd_ptr_r) + 1'b1)
    else $error("queue read pointer did not advance on pop");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ----- rtl/rspe_lfsr.sv -----
// back end: remainder register with constant gf(256) feedback multipliers
// depends on rspe_pkg; hands finished remainders to rspe_unload
module rspe_lfsr (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  rspe_pkg::q_item_t q_item,
  output logic              q_pop,
  output rspe_pkg::load_t   load,
  input  logic              load_ready
);
  import rspe_pkg::*;

  rem_t  rem_r, rem_nxt;
  rem_t  shifted;
  byte_t factor;
  logic  take;

  assign factor = q_item.data ^ rem_r[0];
  assign take   = q_valid && (!q_item.eom || load_ready);
  assign q_pop  = take;

  always_comb begin
    for (int i = 0; i < PARITY_COUNT - 1; i++) begin
      shifted[i] = rem_r[i+1] ^ gf_mul(GEN_COEF[i], factor);
    end
    shifted[PARITY_COUNT-1] = gf_mul(GEN_COEF[PARITY_COUNT-1], factor);
  end

  always_comb begin
    rem_nxt = rem_r;
    if (take) begin
      rem_nxt = q_item.eom ? '0 : shifted;
    end
    load.valid  = q_valid && q_item.eom;
    load.parity = shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  a_clear_after_eom: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_item.eom |=> rem_r == '0)
    else $error("remainder not cleared after end of message");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> rem_r == $past(rem_r))
    else $error("remainder changed without a transaction");

  a_eom_waits_for_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_item.eom && !load_ready |-> !q_pop)
    else $error("end byte taken while output buffer busy");

endmodule

// ----- rtl/rspe_unload.sv -----
// parity output buffer: shifts a finished remainder out one byte per transaction
// depends on rspe_pkg; fed by rspe_lfsr
module rspe_unload (
  input  logic            clk,
  input  logic            rst_n,
  input  rspe_pkg::load_t load,
  output logic            load_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_parity_byte,
  output logic            out_last_parity
);
  import rspe_pkg::*;

  rem_t             buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_take;
  logic             load_take;

  assign out_valid       = (cnt_r != '0);
  assign out_parity_byte = buf_r[0];
  assign out_last_parity = (cnt_r == CNT_W'(1));
  assign out_take        = out_valid && !out_stall;
  assign load_ready      = (cnt_r == '0) || (out_last_parity && !out_stall);
  assign load_take       = load.valid && load_ready;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (out_take) begin
      for (int i = 0; i < PARITY_COUNT - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      buf_nxt[PARITY_COUNT-1] = '0;
      cnt_nxt = cnt_r - 1'b1;
    end
    if (load_take) begin
      buf_nxt = load.parity;
      cnt_nxt = CNT_W'(PARITY_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PARITY_COUNT))
    else $error("parity count above parity length");

  a_load_sets_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    load_take |=> cnt_r == CNT_W'(PARITY_COUNT))
    else $error("load did not start a full parity run");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_take |-> cnt_r == '0 || out_take && out_last_parity)
    else $error("load overwrote pending parity");

endmodule

// ----- rtl/reed_solomon_parity_encoder.sv -----
// top level of the systematic reed-solomon parity encoder, gf(256) poly 0x11d
// depends on rspe_pkg, rspe_queue, rspe_lfsr and rspe_unload
//
// usage:
//   input channel: one message byte per transaction (in_data_byte), with
//   in_end_of_message high on the final byte. no length check is made.
//   output channel: after the final byte, PARITY_COUNT parity bytes, highest
//   coefficient first; out_last_parity marks the last one.
// flow and throughput:
//   a byte enters a two-entry queue at its transaction and is absorbed by
//   the remainder register from there; one byte per cycle is sustained while
//   no end byte waits. the first parity byte is valid in the cycle after the
//   end-marked byte is taken, then one parity byte per cycle while out_stall is low.
//   the next message is absorbed while parity is still shifting out; its end
//   byte waits in the queue until the output buffer's last byte is taken.
// stall: a stalled output holds its byte; an end byte waiting on it holds
//   the queue, which then fills and raises in_stall.
//   reset clears the remainder, the queue and any pending parity.
module reed_solomon_parity_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_parity_byte,
  output logic       out_last_parity
);
  import rspe_pkg::*;

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;
  load_t   load;
  logic    load_ready;

  rspe_queue u_queue (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  rspe_lfsr u_lfsr (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .load       (load),
    .load_ready (load_ready)
  );

  rspe_unload u_unload (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .load_ready      (load_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_parity_byte (out_parity_byte),
    .out_last_parity (out_last_parity)
  );

endmodule
